[design/navas_pkg.sv]
// Package for the navigation aiding mode sequencer.
// Holds the payload, configuration and decision types and the fixed timing constants.
// No dependencies.
`default_nettype none
package navas_pkg;

  localparam int TsCount = 7;

  // Timestamp slots, indexed like the sensor event bits.
  localparam logic [2:0] TS_FLOW_SEEN  = 3'd0;
  localparam logic [2:0] TS_FLOW_VALID = 3'd1;
  localparam logic [2:0] TS_FLOW_FUSED = 3'd2;
  localparam logic [2:0] TS_POS_PASS   = 3'd3;
  localparam logic [2:0] TS_VEL_PASS   = 3'd4;
  localparam logic [2:0] TS_TAS_PASS   = 3'd5;
  localparam logic [2:0] TS_RANGE      = 3'd6;

  localparam logic [31:0] FLOW_TIMEOUT_MS = 32'd5000;
  localparam logic [31:0] RANGE_FRESH_MS  = 32'd500;
  localparam logic [31:0] FLOW_PRESENT_MS = 32'd200;
  localparam logic [1:0]  GPS_PROHIBITED  = 2'd3;

  // Timeout action codes.
  localparam logic [1:0] ACT_KEEP  = 2'd0;
  localparam logic [1:0] ACT_SET   = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_GPS_FUSION_MODE  = 3'd0;
  localparam logic [2:0] REG_FLOW_NAV_ENABLED = 3'd1;
  localparam logic [2:0] REG_TILT_DRIFT_MAX   = 3'd2;
  localparam logic [2:0] REG_POS_RETRY_NO_VEL = 3'd3;
  localparam logic [2:0] REG_POS_RETRY_USE_VEL = 3'd4;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_REL  = 2'd1,
    MODE_ABS  = 2'd2
  } mode_t;

  typedef logic [TsCount-1:0][31:0] ts_array_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [6:0]  sensor_events;
    logic        tilt_aligned;
    logic        yaw_aligned;
    logic        gyro_bias_learned;
    logic        origin_valid;
    logic        gps_good;
    logic        gps_data_ready;
  } in_item_t;

  typedef struct packed {
    logic [1:0] aiding_mode;
    logic       mode_changed;
    logic [1:0] pos_timeout_action;
    logic [1:0] vel_timeout_action;
    logic       tas_timeout_set;
    logic       gps_unavailable_set;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  gps_fusion_mode;
    logic        flow_nav_enabled;
    logic [15:0] tilt_drift_max_ms;
    logic [15:0] pos_retry_no_vel_ms;
    logic [15:0] pos_retry_use_vel_ms;
  } cfg_t;

  typedef struct packed {
    mode_t      mode;
    logic       changed;
    logic [1:0] pos_act;
    logic [1:0] vel_act;
    logic       tas_set;
    logic       gps_na;
    logic       stamp_flow;
    logic       stamp_pos_vel;
  } decision_t;

endpackage
`default_nettype wire

[design/nav_aiding_mode_sequencer_unit.sv]
// Navigation aiding mode sequencer, top level.
// The result of an input transfer is registered in the output register.
// Throughput: one item per cycle while the output is not stalled; the mode rules and the timestamp update settle
// in the cycle of the input transfer, so the next item sees the updated state.
// Reset (rst, synchronous): mode none, all timestamps zero, registers at defaults.
// Depends on navas_pkg and navas_rules.
`default_nettype none
module nav_aiding_mode_sequencer_unit (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  navas_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  wire                  out_ready,
  output navas_pkg::out_item_t out_item,
  input  wire                  psel,
  input  wire                  penable,
  input  wire                  pwrite,
  input  wire  [4:0]           paddr,
  input  wire  [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import navas_pkg::*;

  cfg_t      cfg;
  mode_t     mode;
  ts_array_t ts;
  ts_array_t ts_stamped;
  ts_array_t ts_next;
  decision_t dec;
  logic      in_fire;
  logic      cfg_wr;
  logic [2:0] reg_idx;

  assign pready   = 1'b1;
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign cfg_wr   = psel && penable && pwrite;
  assign reg_idx  = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gps_fusion_mode      <= 2'd0;
      cfg.flow_nav_enabled     <= 1'b0;
      cfg.tilt_drift_max_ms    <= 16'd15000;
      cfg.pos_retry_no_vel_ms  <= 16'd7000;
      cfg.pos_retry_use_vel_ms <= 16'd10000;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_GPS_FUSION_MODE:   cfg.gps_fusion_mode      <= pwdata[1:0];
        REG_FLOW_NAV_ENABLED:  cfg.flow_nav_enabled     <= pwdata[0];
        REG_TILT_DRIFT_MAX:    cfg.tilt_drift_max_ms    <= pwdata[15:0];
        REG_POS_RETRY_NO_VEL:  cfg.pos_retry_no_vel_ms  <= pwdata[15:0];
        REG_POS_RETRY_USE_VEL: cfg.pos_retry_use_vel_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GPS_FUSION_MODE:   prdata = {30'd0, cfg.gps_fusion_mode};
      REG_FLOW_NAV_ENABLED:  prdata = {31'd0, cfg.flow_nav_enabled};
      REG_TILT_DRIFT_MAX:    prdata = {16'd0, cfg.tilt_drift_max_ms};
      REG_POS_RETRY_NO_VEL:  prdata = {16'd0, cfg.pos_retry_no_vel_ms};
      REG_POS_RETRY_USE_VEL: prdata = {16'd0, cfg.pos_retry_use_vel_ms};
      default:               prdata = 32'd0;
    endcase
  end

  // This transfer's events are stamped before the rules look at the ages.
  always_comb begin
    for (int i = 0; i < TsCount; i++) begin
      ts_stamped[i] = in_item.sensor_events[i] ? in_item.now_ms : ts[i];
    end
  end

  navas_rules u_rules (
    .cur_mode (mode),
    .ts       (ts_stamped),
    .item     (in_item),
    .cfg      (cfg),
    .dec      (dec)
  );

  always_comb begin
    ts_next = ts_stamped;
    if (dec.stamp_flow) begin
      ts_next[TS_FLOW_VALID] = in_item.now_ms;
      ts_next[TS_FLOW_FUSED] = in_item.now_ms;
    end
    if (dec.stamp_pos_vel) begin
      ts_next[TS_POS_PASS] = in_item.now_ms;
      ts_next[TS_VEL_PASS] = in_item.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_NONE;
      ts        <= '0;
      out_valid <= 1'b0;
    end else if (in_fire) begin
      mode      <= dec.mode;
      ts        <= ts_next;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_item.aiding_mode         <= dec.mode;
      out_item.mode_changed        <= dec.changed;
      out_item.pos_timeout_action  <= dec.pos_act;
      out_item.vel_timeout_action  <= dec.vel_act;
      out_item.tas_timeout_set     <= dec.tas_set;
      out_item.gps_unavailable_set <= dec.gps_na;
    end
  end

endmodule
`default_nettype wire

[design/navas_rules.sv]
// Mode rules of the aiding sequencer: ages, timeout tests and the next mode.
// Purely combinational; depends on navas_pkg.
`default_nettype none
module navas_rules (
  input  navas_pkg::mode_t     cur_mode,
  input  navas_pkg::ts_array_t ts,
  input  navas_pkg::in_item_t  item,
  input  navas_pkg::cfg_t      cfg,
  output navas_pkg::decision_t dec
);
  import navas_pkg::*;

  logic [TsCount-1:0][31:0] age;
  logic        gps_allowed;
  logic        ready_gps;
  logic        stable;
  logic        flow_present;
  logic        sensor_to;
  logic        fuse_to;
  logic [15:0] tmin_a;
  logic [15:0] tmin;
  logic [31:0] tmin_w;
  logic [31:0] tilt_w;
  logic [31:0] pos_lim_w;
  logic        flow_used;
  logic        tas_used;
  logic        pos_used;
  logic        vel_used;
  logic        att_aid;
  logic        vel_aid;
  logic        att_crit;
  logic        pos_crit;
  logic        range_fresh;

  // The timestamps seen here already carry this transfer's event stamps.
  always_comb begin
    for (int i = 0; i < TsCount; i++) begin
      age[i] = item.now_ms - ts[i];
    end
  end

  always_comb begin
    gps_allowed  = cfg.gps_fusion_mode != GPS_PROHIBITED;
    ready_gps    = item.origin_valid && item.tilt_aligned && item.yaw_aligned &&
                   item.gps_good && gps_allowed && item.gps_data_ready;
    stable       = item.tilt_aligned && item.yaw_aligned && item.gyro_bias_learned;
    flow_present = age[TS_FLOW_SEEN] < FLOW_PRESENT_MS;
    sensor_to    = age[TS_FLOW_VALID] > FLOW_TIMEOUT_MS;
    fuse_to      = age[TS_FLOW_FUSED] > FLOW_TIMEOUT_MS;
    range_fresh  = age[TS_RANGE] < RANGE_FRESH_MS;

    tmin_a = (cfg.pos_retry_no_vel_ms < cfg.pos_retry_use_vel_ms) ?
             cfg.pos_retry_no_vel_ms : cfg.pos_retry_use_vel_ms;
    tmin   = (cfg.tilt_drift_max_ms < tmin_a) ? cfg.tilt_drift_max_ms : tmin_a;
    tmin_w = {16'd0, tmin};
    tilt_w = {16'd0, cfg.tilt_drift_max_ms};

    flow_used = age[TS_FLOW_FUSED] <= tmin_w;
    tas_used  = age[TS_TAS_PASS] <= tmin_w;
    pos_used  = age[TS_POS_PASS] <= tmin_w;
    vel_used  = age[TS_VEL_PASS] <= tmin_w;
    att_aid   = pos_used || vel_used || flow_used || tas_used;
    vel_aid   = vel_used || tas_used || flow_used;
    pos_lim_w = vel_aid ? {16'd0, cfg.pos_retry_use_vel_ms} :
                          {16'd0, cfg.pos_retry_no_vel_ms};

    att_crit = !att_aid && (age[TS_FLOW_FUSED] > tilt_w) && (age[TS_TAS_PASS] > tilt_w) &&
               (age[TS_POS_PASS] > tilt_w) && (age[TS_VEL_PASS] > tilt_w);
    pos_crit = !pos_used && (age[TS_POS_PASS] > pos_lim_w);

    dec = '0;
    dec.mode    = cur_mode;
    dec.pos_act = ACT_KEEP;
    dec.vel_act = ACT_KEEP;

    case (cur_mode)
      MODE_NONE: begin
        if (gps_allowed && ready_gps && stable) begin
          dec.mode = MODE_ABS;
        end else if (flow_present && cfg.flow_nav_enabled && stable) begin
          dec.mode = MODE_REL;
        end
      end
      MODE_REL: begin
        if (gps_allowed && ready_gps) begin
          dec.mode = MODE_ABS;
        end else if (sensor_to || fuse_to) begin
          dec.mode = MODE_NONE;
        end
      end
      MODE_ABS: begin
        if (att_crit) begin
          dec.mode    = MODE_NONE;
          dec.pos_act = ACT_SET;
          dec.vel_act = ACT_SET;
          dec.tas_set = 1'b1;
          dec.gps_na  = 1'b1;
        end else if (pos_crit) begin
          // Fall back to no aiding only when flow navigation could take over.
          if (cfg.flow_nav_enabled && flow_present && range_fresh) begin
            dec.mode = MODE_NONE;
          end
          dec.pos_act = ACT_SET;
          dec.vel_act = ACT_SET;
          dec.gps_na  = 1'b1;
        end
      end
      default: begin
        dec.mode = cur_mode;
      end
    endcase

    dec.changed = dec.mode != cur_mode;

    // Entering a mode overrides the position and velocity actions taken by the timeout rules.
    if (dec.changed) begin
      case (dec.mode)
        MODE_NONE: begin
          dec.pos_act = ACT_SET;
          dec.vel_act = ACT_SET;
        end
        MODE_REL: begin
          dec.pos_act    = ACT_SET;
          dec.vel_act    = ACT_SET;
          dec.stamp_flow = 1'b1;
        end
        MODE_ABS: begin
          dec.pos_act       = ACT_CLEAR;
          dec.vel_act       = ACT_CLEAR;
          dec.stamp_pos_vel = 1'b1;
        end
        default: begin
          dec.pos_act = ACT_KEEP;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
